// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the height interpolation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Labeled concurrent assertion on the rising edge of clk, quiet while rst_n is low.
`define HTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Labeled assertion whose consequent must hold in the cycle after its trigger.
`define HTI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hti_pkg.sv =====
// Shared types, widths and constants for the height interpolation unit.
package hti_pkg;

  localparam int GRID_MAX    = 256;
  localparam int FRAC_BITS   = 8;
  localparam int COORD_W     = 16;
  localparam int INT_W       = COORD_W - FRAC_BITS;
  localparam int SIZE_W      = 9;
  localparam int LIM_W       = SIZE_W + FRAC_BITS;
  localparam int ROW_W       = INT_W + SIZE_W;
  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int H_W         = 24;
  localparam int D_W         = H_W + 1;
  localparam int W_W         = FRAC_BITS + 1;
  localparam int P_W         = D_W + W_W + 1;
  localparam int T_W         = P_W - FRAC_BITS;
  localparam int S_W         = T_W + 2;
  localparam int N_CORNERS   = 4;

  localparam logic [SIZE_W-1:0] GRID_RESET = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] GRID_MAX_V = SIZE_W'(GRID_MAX);
  localparam logic [SIZE_W-1:0] GRID_MIN_V = SIZE_W'(2);
  localparam logic [W_W-1:0]    ONE_FIX    = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic signed [S_W-1:0] H_MAX_S = S_W'((1 << (H_W - 1)) - 1);
  localparam logic signed [S_W-1:0] H_MIN_S = S_W'(-(1 << (H_W - 1)));

  // Corner positions in the cell: (x, z), (x+1, z), (x, z+1), (x+1, z+1).
  localparam int CRN_00 = 0;
  localparam int CRN_10 = 1;
  localparam int CRN_01 = 2;
  localparam int CRN_11 = 3;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } hti_action_t;

  typedef struct packed {
    logic                 in_range;
    logic                 upper;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fz;
  } hti_meta_t;

endpackage

// ===== hdl/hti_height_bank.sv =====
// One copy of the height store: one write port, one registered read port.
module hti_height_bank (
  input  logic                        clk,
  input  logic                        we_i,
  input  logic [hti_pkg::ADDR_W-1:0]  waddr_i,
  input  logic [hti_pkg::H_W-1:0]     wdata_i,
  input  logic                        re_i,
  input  logic [hti_pkg::ADDR_W-1:0]  raddr_i,
  output logic [hti_pkg::H_W-1:0]     rdata_o
);
  import hti_pkg::*;

  logic [H_W-1:0] mem [STORE_DEPTH];
  logic [H_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk) begin
    if (re_i) begin
      rdata_r <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_r;

endmodule

// ===== hdl/hti_query_front.sv =====
// Range check, triangle select and corner address generation for a query.
module hti_query_front (
  input  logic [hti_pkg::SIZE_W-1:0]                      grid_size_i,
  input  logic [hti_pkg::COORD_W-1:0]                     x_coord_i,
  input  logic [hti_pkg::COORD_W-1:0]                     z_coord_i,
  output hti_pkg::hti_meta_t                              meta_o,
  output logic [hti_pkg::N_CORNERS-1:0][hti_pkg::ADDR_W-1:0] addr_o
);
  import hti_pkg::*;

  logic [SIZE_W-1:0]    size_eff;
  logic [LIM_W-1:0]     limit;
  logic [INT_W-1:0]     xi;
  logic [INT_W-1:0]     zi;
  logic [ROW_W-1:0]     row_base;
  logic [ADDR_W-1:0]    base;
  logic [ADDR_W-1:0]    size_a;
  logic [W_W-1:0]       frac_sum;

  // Clamp the grid side to the largest supported grid.
  assign size_eff = (grid_size_i > GRID_MAX_V) ? GRID_MAX_V : grid_size_i;
  assign limit    = {size_eff - SIZE_W'(1), {FRAC_BITS{1'b0}}};

  assign xi = x_coord_i[COORD_W-1:FRAC_BITS];
  assign zi = z_coord_i[COORD_W-1:FRAC_BITS];

  assign row_base = ROW_W'(xi) * ROW_W'(size_eff);
  assign base     = row_base[ADDR_W-1:0] + ADDR_W'(zi);
  assign size_a   = ADDR_W'(size_eff);

  // Addresses wrap modulo the store depth.
  assign addr_o[CRN_00] = base;
  assign addr_o[CRN_10] = base + size_a;
  assign addr_o[CRN_01] = base + ADDR_W'(1);
  assign addr_o[CRN_11] = base + size_a + ADDR_W'(1);

  assign frac_sum = W_W'(x_coord_i[FRAC_BITS-1:0]) + W_W'(z_coord_i[FRAC_BITS-1:0]);

  always_comb begin
    meta_o.in_range = (size_eff >= GRID_MIN_V)
                   && (LIM_W'(x_coord_i) < limit)
                   && (LIM_W'(z_coord_i) < limit);
    meta_o.upper    = (frac_sum >= ONE_FIX);
    meta_o.fx       = x_coord_i[FRAC_BITS-1:0];
    meta_o.fz       = z_coord_i[FRAC_BITS-1:0];
  end

endmodule

// ===== hdl/hti_interp.sv =====
// Interpolation pipeline: corner differences, weighted products, sum and clamp.
module hti_interp (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            en_i,
  input  logic                                            query_i,
  input  hti_pkg::hti_meta_t                              meta_i,
  input  logic [hti_pkg::N_CORNERS-1:0][hti_pkg::H_W-1:0] corner_i,
  output logic                                            res_vld_o,
  output logic [hti_pkg::H_W-1:0]                         res_height_o,
  output logic                                            res_in_range_o
);
  import hti_pkg::*;
  `include "assert_macros.svh"

  // Stage 1: query tag alongside the bank read data.
  logic                  s1_vld_r;
  hti_meta_t             s1_meta_r;

  // Stage 2: selected base corner, differences and weights.
  logic                  s2_vld_r;
  logic                  s2_inr_r;
  logic signed [H_W-1:0] s2_base_r, s2_base_nxt;
  logic signed [D_W-1:0] s2_d1_r, s2_d1_nxt;
  logic signed [D_W-1:0] s2_d2_r, s2_d2_nxt;
  logic [W_W-1:0]        s2_w1_r, s2_w1_nxt;
  logic [W_W-1:0]        s2_w2_r, s2_w2_nxt;

  // Stage 3: products.
  logic                  s3_vld_r;
  logic                  s3_inr_r;
  logic signed [H_W-1:0] s3_base_r;
  logic signed [P_W-1:0] s3_p1_r, s3_p1_nxt;
  logic signed [P_W-1:0] s3_p2_r, s3_p2_nxt;

  logic signed [H_W-1:0] h00, h10, h01, h11;
  logic signed [T_W-1:0] t1, t2;
  logic signed [S_W-1:0] sum;
  logic signed [S_W-1:0] sat;

  assign h00 = $signed(corner_i[CRN_00]);
  assign h10 = $signed(corner_i[CRN_10]);
  assign h01 = $signed(corner_i[CRN_01]);
  assign h11 = $signed(corner_i[CRN_11]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en_i) begin
      s1_vld_r <= query_i;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_comb begin
    if (s1_meta_r.upper) begin
      s2_base_nxt = h11;
      s2_d1_nxt   = D_W'(h10) - D_W'(h11);
      s2_d2_nxt   = D_W'(h01) - D_W'(h11);
      s2_w1_nxt   = ONE_FIX - W_W'(s1_meta_r.fz);
      s2_w2_nxt   = ONE_FIX - W_W'(s1_meta_r.fx);
    end else begin
      s2_base_nxt = h00;
      s2_d1_nxt   = D_W'(h10) - D_W'(h00);
      s2_d2_nxt   = D_W'(h01) - D_W'(h00);
      s2_w1_nxt   = W_W'(s1_meta_r.fx);
      s2_w2_nxt   = W_W'(s1_meta_r.fz);
    end
  end

  assign s3_p1_nxt = P_W'(s2_d1_r) * P_W'($signed({1'b0, s2_w1_r}));
  assign s3_p2_nxt = P_W'(s2_d2_r) * P_W'($signed({1'b0, s2_w2_r}));

  always_ff @(posedge clk) begin
    if (en_i) begin
      s1_meta_r <= meta_i;
      s2_inr_r  <= s1_meta_r.in_range;
      s2_base_r <= s2_base_nxt;
      s2_d1_r   <= s2_d1_nxt;
      s2_d2_r   <= s2_d2_nxt;
      s2_w1_r   <= s2_w1_nxt;
      s2_w2_r   <= s2_w2_nxt;
      s3_inr_r  <= s2_inr_r;
      s3_base_r <= s2_base_r;
      s3_p1_r   <= s3_p1_nxt;
      s3_p2_r   <= s3_p2_nxt;
    end
  end

  // Arithmetic right shift floors toward minus infinity.
  assign t1  = s3_p1_r[P_W-1:FRAC_BITS];
  assign t2  = s3_p2_r[P_W-1:FRAC_BITS];
  assign sum = S_W'(s3_base_r) + S_W'(t1) + S_W'(t2);

  always_comb begin
    priority if (sum > H_MAX_S) begin
      sat = H_MAX_S;
    end else if (sum < H_MIN_S) begin
      sat = H_MIN_S;
    end else begin
      sat = sum;
    end
  end

  assign res_vld_o      = s3_vld_r;
  assign res_in_range_o = s3_inr_r;
  assign res_height_o   = s3_inr_r ? sat[H_W-1:0] : '0;

  `HTI_ASSERT(a_weights_in_cell,
    s2_vld_r |-> ((W_W+1)'(s2_w1_r) + (W_W+1)'(s2_w2_r) <= (W_W+1)'(ONE_FIX)),
    "triangle weights exceed one")
  `HTI_ASSERT_NXT(a_s3_holds_on_stall, !en_i && s3_vld_r,
    s3_vld_r && $stable(s3_p1_r) && $stable(s3_p2_r),
    "product stage changed while stalled")

endmodule

// ===== hdl/heightfield_triangle_interpolate_unit.sv =====
// Top level of the height grid triangle interpolation unit.
//
// Usage:
//   Input channel (in_valid / in_stall): each word is either a grid write
//   (in_action = write: store in_entry_height at in_entry_index, no result)
//   or a query (in_action = query: Q8.8 in_x_coord / in_z_coord). A query
//   yields one result word on out_valid / out_stall: out_height (Q15.8) and
//   out_in_range; positions outside [0, size-1) give height 0, in_range 0.
//   Config channel (cfg_valid / cfg_ready): cfg_grid_size sets the grid side;
//   cfg_ready is always high. Write it only while the unit is idle.
// Timing:
//   One word per cycle sustained while in_stall is low. A query accepted
//   passes the bank read, then the difference, product and sum/clamp
//   stages into the output register. Four copies of the height store, each
//   written on every grid write, give the four cell corners in one read.
//   A write is visible to any query accepted at a later edge.
// Reset: clears all valids and loads a grid side of 256; the store contents
//   stay undefined until written.
// Stall: a two-entry output (register plus skid) absorbs a stalled receiver;
//   in_stall rises only once the skid entry holds a result.
module heightfield_triangle_interpolate_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic [hti_pkg::ADDR_W-1:0]          in_entry_index,
  input  logic signed [hti_pkg::H_W-1:0]      in_entry_height,
  input  logic [hti_pkg::COORD_W-1:0]         in_x_coord,
  input  logic [hti_pkg::COORD_W-1:0]         in_z_coord,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hti_pkg::H_W-1:0]      out_height,
  output logic                                out_in_range,
  // config channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hti_pkg::SIZE_W-1:0]          cfg_grid_size
);
  import hti_pkg::*;
  `include "assert_macros.svh"

  logic [SIZE_W-1:0]                    grid_size_r;
  logic                                 en;
  logic                                 in_acc;
  logic                                 wr_acc;
  logic                                 q_acc;
  hti_meta_t                            meta;
  logic [N_CORNERS-1:0][ADDR_W-1:0]     rd_addr;
  logic [N_CORNERS-1:0][H_W-1:0]        corner;

  logic                                 res_vld;
  logic [H_W-1:0]                       res_height;
  logic                                 res_in_range;

  logic                                 out_valid_r, out_valid_nxt;
  logic [H_W-1:0]                       out_height_r, out_height_nxt;
  logic                                 out_in_range_r, out_in_range_nxt;
  logic                                 skid_full_r, skid_full_nxt;
  logic [H_W-1:0]                       skid_height_r, skid_height_nxt;
  logic                                 skid_in_range_r, skid_in_range_nxt;
  logic                                 take;
  logic                                 push;

  // Config register: always ready, write on valid.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GRID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      grid_size_r <= cfg_grid_size;
    end
  end

  // Pipeline advances whenever the skid entry is free.
  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;
  assign in_acc   = in_valid && !in_stall;
  assign wr_acc   = in_acc && (hti_action_t'(in_action) == ACT_WRITE);
  assign q_acc    = in_acc && (hti_action_t'(in_action) == ACT_QUERY);

  hti_query_front u_front (
    .grid_size_i (grid_size_r),
    .x_coord_i   (in_x_coord),
    .z_coord_i   (in_z_coord),
    .meta_o      (meta),
    .addr_o      (rd_addr)
  );

  // One store copy per cell corner; every grid write lands in all of them.
  for (genvar g = 0; g < N_CORNERS; g++) begin : g_bank
    hti_height_bank u_bank (
      .clk     (clk),
      .we_i    (wr_acc),
      .waddr_i (in_entry_index),
      .wdata_i (in_entry_height),
      .re_i    (en),
      .raddr_i (rd_addr[g]),
      .rdata_o (corner[g])
    );
  end

  hti_interp u_interp (
    .clk            (clk),
    .rst_n          (rst_n),
    .en_i           (en),
    .query_i        (q_acc),
    .meta_i         (meta),
    .corner_i       (corner),
    .res_vld_o      (res_vld),
    .res_height_o   (res_height),
    .res_in_range_o (res_in_range)
  );

  // Output register with one skid entry behind it.
  assign take = out_valid_r && !out_stall;
  assign push = en && res_vld;

  always_comb begin
    out_valid_nxt     = out_valid_r;
    out_height_nxt    = out_height_r;
    out_in_range_nxt  = out_in_range_r;
    skid_full_nxt     = skid_full_r;
    skid_height_nxt   = skid_height_r;
    skid_in_range_nxt = skid_in_range_r;
    priority if (skid_full_r) begin
      // drain the skid entry into the output once the word is taken
      if (take) begin
        out_valid_nxt    = 1'b1;
        out_height_nxt   = skid_height_r;
        out_in_range_nxt = skid_in_range_r;
        skid_full_nxt    = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_valid_nxt    = 1'b1;
        out_height_nxt   = res_height;
        out_in_range_nxt = res_in_range;
      end else begin
        skid_full_nxt     = 1'b1;
        skid_height_nxt   = res_height;
        skid_in_range_nxt = res_in_range;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_height_r    <= out_height_nxt;
    out_in_range_r  <= out_in_range_nxt;
    skid_height_r   <= skid_height_nxt;
    skid_in_range_r <= skid_in_range_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_height   = $signed(out_height_r);
  assign out_in_range = out_in_range_r;

  `HTI_ASSERT(a_skid_behind_out, skid_full_r |-> out_valid_r,
    "skid entry full with empty output register")
  `HTI_ASSERT(a_skid_fill_cause, $rose(skid_full_r) |-> $past(out_valid_r && out_stall),
    "skid entry filled without a stalled output")

endmodule

// ===== tb/sv/heightfield_triangle_interpolate_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the height grid triangle interpolation unit.
module heightfield_triangle_interpolate_unit_tb;
  import hti_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 8;
  // Headroom past the result pipeline when waiting for the unit to settle.
  localparam int PIPE_SLACK   = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 6;
  localparam int REPORT_MAX   = 10;
  localparam int RANDOM_WORDS = 1850;
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int ONE_W        = 1 << FRAC_BITS;

  localparam longint HEIGHT_HI = (longint'(1) << (H_W - 1)) - 1;
  localparam longint HEIGHT_LO = -(longint'(1) << (H_W - 1));
  localparam logic [H_W-1:0] HEIGHT_TOP = {1'b0, {(H_W-1){1'b1}}};
  localparam logic [H_W-1:0] HEIGHT_BOT = {1'b1, {(H_W-1){1'b0}}};

  typedef struct packed {
    logic signed [H_W-1:0] height;
    logic                  in_range;
  } height_res_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_QUERY,
    ROW_GRID
  } row_kind_t;

  // One directed step: a grid write, a query or a new grid side.
  // Queries with typed set carry their result inline; the rest are predicted.
  typedef struct packed {
    row_kind_t            kind;
    logic [ADDR_W-1:0]    idx;
    logic [H_W-1:0]       hgt;
    logic [COORD_W-1:0]   xq;
    logic [COORD_W-1:0]   zq;
    logic [SIZE_W-1:0]    side;
    logic                 typed;
    logic [H_W-1:0]       exp_h;
    logic                 exp_r;
  } stim_row_t;

  localparam int NUM_ROWS = 29;
  localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
    // Reset side of 256: nothing written yet, so only positions past the edge.
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'hFFFF, 16'hFFFF, 9'd0, 1'b1, 24'h000000, 1'b0},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'hFF00, 16'h0000, 9'd0, 1'b1, 24'h000000, 1'b0},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'h0000, 16'hFF00, 9'd0, 1'b1, 24'h000000, 1'b0},
    // First cell with full-scale corners.
    '{ROW_WRITE, 16'h0000, 24'h7FFFFF, 16'h0000, 16'h0000, 9'd0, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE, 16'h0001, 24'h800000, 16'h0000, 16'h0000, 9'd0, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE, 16'h0100, 24'h000000, 16'h0000, 16'h0000, 9'd0, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE, 16'h0101, 24'h3C5A96, 16'h0000, 16'h0000, 9'd0, 1'b0, 24'h000000, 1'b0},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'h0000, 16'h0000, 9'd0, 1'b1, 24'h7FFFFF, 1'b1},
    // Fractions summing exactly to one, one below, and both at maximum.
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'h0080, 16'h0080, 9'd0, 1'b0, 24'h000000, 1'b0},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'h00FF, 16'h0000, 9'd0, 1'b0, 24'h000000, 1'b0},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'h0001, 16'h00FE, 9'd0, 1'b0, 24'h000000, 1'b0},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'h00FF, 16'h00FF, 9'd0, 1'b0, 24'h000000, 1'b0},
    // Last cell of the full grid, top of the address space.
    '{ROW_WRITE, 16'hFFFF, 24'hFFFFFF, 16'h0000, 16'h0000, 9'd0, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE, 16'hFFFE, 24'h000100, 16'h0000, 16'h0000, 9'd0, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE, 16'hFEFF, 24'h7FFFFF, 16'h0000, 16'h0000, 9'd0, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE, 16'hFEFE, 24'h800000, 16'h0000, 16'h0000, 9'd0, 1'b0, 24'h000000, 1'b0},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'hFEFF, 16'hFEFF, 9'd0, 1'b0, 24'h000000, 1'b0},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'hFEFF, 16'hFF00, 9'd0, 1'b1, 24'h000000, 1'b0},
    // Smallest usable grid: one cell.
    '{ROW_GRID,  16'h0000, 24'h000000, 16'h0000, 16'h0000, 9'd2, 1'b0, 24'h000000, 1'b0},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'h00FF, 16'h00FF, 9'd0, 1'b0, 24'h000000, 1'b0},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'h0100, 16'h0000, 9'd0, 1'b1, 24'h000000, 1'b0},
    // Sides below two: every position lies outside.
    '{ROW_GRID,  16'h0000, 24'h000000, 16'h0000, 16'h0000, 9'd0, 1'b0, 24'h000000, 1'b0},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'h0000, 16'h0000, 9'd0, 1'b1, 24'h000000, 1'b0},
    '{ROW_GRID,  16'h0000, 24'h000000, 16'h0000, 16'h0000, 9'd1, 1'b0, 24'h000000, 1'b0},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'h0080, 16'h0040, 9'd0, 1'b1, 24'h000000, 1'b0},
    // Side above the maximum acts as the maximum.
    '{ROW_GRID,  16'h0000, 24'h000000, 16'h0000, 16'h0000, 9'd511, 1'b0, 24'h000000, 1'b0},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'h0000, 16'h0000, 9'd0, 1'b1, 24'h7FFFFF, 1'b1},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'hFF00, 16'h0000, 9'd0, 1'b1, 24'h000000, 1'b0},
    '{ROW_QUERY, 16'h0000, 24'h000000, 16'hFEFF, 16'h0080, 9'd0, 1'b0, 24'h000000, 1'b0}
  };

  // Grid sides for the random phases; extremes and odd sizes both.
  localparam int N_PHASES    = 11;
  localparam int QUIET_PHASE = 4;
  localparam int HOLD_PHASE  = 5;
  localparam int PAUSE_PHASE = 8;
  localparam logic [SIZE_W-1:0] PHASE_SIDES [N_PHASES] = '{
    9'd256, 9'd3, 9'd17, 9'd2, 9'd64, 9'd511, 9'd130, 9'd1, 9'd255, 9'd0, 9'd256
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_action;
  logic [ADDR_W-1:0]     in_entry_index;
  logic signed [H_W-1:0] in_entry_height;
  logic [COORD_W-1:0]    in_x_coord;
  logic [COORD_W-1:0]    in_z_coord;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [H_W-1:0] out_height;
  logic                  out_in_range;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [SIZE_W-1:0]     cfg_grid_size;

  heightfield_triangle_interpolate_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_entry_index  (in_entry_index),
    .in_entry_height (in_entry_height),
    .in_x_coord      (in_x_coord),
    .in_z_coord      (in_z_coord),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_height      (out_height),
    .out_in_range    (out_in_range),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_grid_size   (cfg_grid_size)
  );

  always #(CLK_HALF) clk = ~clk;

  // Mirror of the height store and the grid side, updated at acceptance.
  logic signed [H_W-1:0] grid_mirror [STORE_DEPTH];
  bit                    written_map [STORE_DEPTH];
  logic [SIZE_W-1:0]     side_reg;

  // Heights still owed by the unit, oldest first.
  height_res_t pending_heights [$];

  int n_words, n_writes, n_queries, n_inside, n_upper, n_outside, n_sides;
  int n_checked, n_mismatch, n_unexpected;
  bit idle_en;
  bit hold_req;
  bit have_cell;
  int unsigned last_xi, last_zi;

  // Side actually in use: anything past the maximum is clipped to it.
  function automatic int unsigned eff_side();
    return (side_reg > GRID_MAX) ? GRID_MAX : side_reg;
  endfunction

  function automatic bit inside_grid(logic [COORD_W-1:0] xq, logic [COORD_W-1:0] zq);
    int unsigned s, lim;
    s = eff_side();
    if (s < 2) return 1'b0;
    lim = (s - 1) << FRAC_BITS;
    return (xq < lim) && (zq < lim);
  endfunction

  function automatic logic [ADDR_W-1:0] corner_addr(int unsigned cx, int unsigned cz);
    return ADDR_W'(cx * eff_side() + cz);
  endfunction

  // Interpolate on the lower-left triangle while fx + fz stays below one,
  // else on the upper-right one; each product floors its fraction bits.
  function automatic height_res_t interp_height(logic [COORD_W-1:0] xq,
                                                logic [COORD_W-1:0] zq);
    height_res_t r;
    int unsigned xi, zi;
    longint fx, fz, c00, c10, c01, c11, acc;
    r.height   = '0;
    r.in_range = 1'b0;
    if (!inside_grid(xq, zq)) return r;
    xi  = xq >> FRAC_BITS;
    zi  = zq >> FRAC_BITS;
    fx  = xq[FRAC_BITS-1:0];
    fz  = zq[FRAC_BITS-1:0];
    c00 = grid_mirror[corner_addr(xi, zi)];
    c10 = grid_mirror[corner_addr(xi + 1, zi)];
    c01 = grid_mirror[corner_addr(xi, zi + 1)];
    c11 = grid_mirror[corner_addr(xi + 1, zi + 1)];
    if (fx + fz < ONE_W)
      acc = c00 + (((c10 - c00) * fx) >>> FRAC_BITS)
                + (((c01 - c00) * fz) >>> FRAC_BITS);
    else
      acc = c11 + (((c10 - c11) * (ONE_W - fz)) >>> FRAC_BITS)
                + (((c01 - c11) * (ONE_W - fx)) >>> FRAC_BITS);
    if (acc > HEIGHT_HI) acc = HEIGHT_HI;
    if (acc < HEIGHT_LO) acc = HEIGHT_LO;
    r.height   = acc[H_W-1:0];
    r.in_range = 1'b1;
    return r;
  endfunction

  // Mostly random heights, with the two full-scale values mixed in.
  function automatic logic [H_W-1:0] rand_height();
    case ($urandom_range(7))
      0:       return HEIGHT_TOP;
      1:       return HEIGHT_BOT;
      default: return H_W'($urandom);
    endcase
  endfunction

  // Offer one word and hold it until the unit takes it, then update the
  // mirror or queue the owed height. Fields the action ignores carry noise.
  task automatic drive_word(hti_action_t act, logic [ADDR_W-1:0] idx,
                            logic [H_W-1:0] hgt, logic [COORD_W-1:0] xq,
                            logic [COORD_W-1:0] zq, bit typed = 1'b0,
                            height_res_t fixed = '0);
    height_res_t res;
    if (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_entry_index  <= idx;
    in_entry_height <= hgt;
    in_x_coord      <= xq;
    in_z_coord      <= zq;
    do @(posedge clk); while (in_stall);
    n_words++;
    if (act == ACT_WRITE) begin
      grid_mirror[idx] = hgt;
      written_map[idx] = 1'b1;
      n_writes++;
    end else begin
      res = typed ? fixed : interp_height(xq, zq);
      n_queries++;
      if (res.in_range) begin
        n_inside++;
        if (xq[FRAC_BITS-1:0] + zq[FRAC_BITS-1:0] >= ONE_W) n_upper++;
      end else begin
        n_outside++;
      end
      pending_heights = {pending_heights, res};
    end
  endtask

  // Write any corner of the query's cell that was never written, so no
  // in-grid query ever reads an empty store entry.
  task automatic fill_corners(logic [COORD_W-1:0] xq, logic [COORD_W-1:0] zq);
    int unsigned xi, zi;
    logic [ADDR_W-1:0] a;
    if (!inside_grid(xq, zq)) return;
    xi = xq >> FRAC_BITS;
    zi = zq >> FRAC_BITS;
    for (int k = 0; k < N_CORNERS; k++) begin
      a = corner_addr(xi + (k & 1), zi + (k >> 1));
      if (!written_map[a])
        drive_word(ACT_WRITE, a, rand_height(), COORD_W'($urandom), COORD_W'($urandom));
    end
    last_xi   = xi;
    last_zi   = zi;
    have_cell = 1'b1;
  endtask

  task automatic ask_height(logic [COORD_W-1:0] xq, logic [COORD_W-1:0] zq,
                            bit typed = 1'b0, height_res_t fixed = '0);
    fill_corners(xq, zq);
    drive_word(ACT_QUERY, ADDR_W'($urandom), H_W'($urandom), xq, zq, typed, fixed);
  endtask

  // Drop valid and wait until every owed height is back; grid writes give
  // no result, so also let the pipeline drain them.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic write_side(logic [SIZE_W-1:0] v);
    settle();
    cfg_valid     <= 1'b1;
    cfg_grid_size <= v;
    do @(posedge clk); while (!cfg_ready);
    side_reg = v;
    n_sides++;
    cfg_valid <= 1'b0;
  endtask

  // One random step: mostly queries inside the grid, some raw positions
  // anywhere, plus writes both scattered and onto the last cell touched.
  task automatic random_word();
    int unsigned pick, s, lim, fx;
    logic [COORD_W-1:0] xq, zq;
    pick = $urandom_range(99);
    s    = eff_side();
    if (pick < 12) begin
      drive_word(ACT_WRITE, ADDR_W'($urandom), rand_height(),
                 COORD_W'($urandom), COORD_W'($urandom));
    end else if (pick < 20 && have_cell) begin
      drive_word(ACT_WRITE,
                 corner_addr(last_xi + $urandom_range(1), last_zi + $urandom_range(1)),
                 rand_height(), COORD_W'($urandom), COORD_W'($urandom));
    end else if (pick < 35 || s < 2) begin
      ask_height(COORD_W'($urandom), COORD_W'($urandom));
    end else begin
      lim = (s - 1) << FRAC_BITS;
      xq  = COORD_W'($urandom_range(lim - 1));
      zq  = COORD_W'($urandom_range(lim - 1));
      // steer some onto the triangle diagonal or just below it
      if ($urandom_range(4) == 0) begin
        fx = xq[FRAC_BITS-1:0];
        zq[FRAC_BITS-1:0] = FRAC_BITS'(ONE_W - fx - $urandom_range(1));
      end
      ask_height(xq, zq);
    end
  endtask

  // Receiver: short random stalls, and on request one long hold-off that
  // backs the unit up until it stalls its input.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Compare every word the unit hands over against the oldest owed height.
  always @(posedge clk) begin : check_heights
    height_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_heights.size() == 0) begin
        n_unexpected++;
        if (n_mismatch + n_unexpected <= REPORT_MAX)
          $display("%0t: result with nothing owed: height %0d in_range %0b",
                   $time, out_height, out_in_range);
      end else begin
        want = pending_heights.pop_front();
        n_checked++;
        if (out_height !== want.height || out_in_range !== want.in_range) begin
          n_mismatch++;
          if (n_mismatch + n_unexpected <= REPORT_MAX)
            $display("%0t: height exp %0d got %0d, in_range exp %0b got %0b",
                     $time, want.height, out_height, want.in_range, out_in_range);
        end
      end
    end
  end

  // Stimulus: reset, directed rows, then the random phases.
  initial begin
    height_res_t fixed_res;
    int target, midpoint;
    bit paused;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_action       <= ACT_WRITE;
    in_entry_index  <= '0;
    in_entry_height <= '0;
    in_x_coord      <= '0;
    in_z_coord      <= '0;
    cfg_valid       <= 1'b0;
    cfg_grid_size   <= '0;
    side_reg  = GRID_RESET;
    idle_en   = 1'b1;
    hold_req  = 1'b0;
    have_cell = 1'b0;
    paused    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      case (DIR_ROWS[i].kind)
        ROW_WRITE: begin
          drive_word(ACT_WRITE, DIR_ROWS[i].idx, DIR_ROWS[i].hgt,
                     COORD_W'($urandom), COORD_W'($urandom));
        end
        ROW_QUERY: begin
          fixed_res.height   = DIR_ROWS[i].exp_h;
          fixed_res.in_range = DIR_ROWS[i].exp_r;
          ask_height(DIR_ROWS[i].xq, DIR_ROWS[i].zq, DIR_ROWS[i].typed, fixed_res);
        end
        default: begin
          write_side(DIR_ROWS[i].side);
        end
      endcase
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_side(PHASE_SIDES[p]);
      // one phase runs with no idling on either side
      idle_en = (p != QUIET_PHASE);
      // receiver holds off while the sender keeps offering words
      if (p == HOLD_PHASE) hold_req = 1'b1;
      target   = n_words + RANDOM_WORDS / N_PHASES;
      midpoint = n_words + RANDOM_WORDS / (2 * N_PHASES);
      while (n_words < target) begin
        random_word();
        // sender pauses mid-phase until every owed height is back
        if (p == PAUSE_PHASE && !paused && n_words >= midpoint) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    settle();
    $display("Covered %0d words: %0d grid writes, %0d queries (%0d interpolated,",
             n_words, n_writes, n_queries, n_inside);
    $display("%0d upper triangle, %0d outside) over %0d grid sides; %0d checked.",
             n_upper, n_outside, n_sides, n_checked);
    if (n_mismatch == 0 && n_unexpected == 0 && pending_heights.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Hard stop in case the unit hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
